>>> design/rfe_pkg.sv
// Shared types, widths and constants of the rational function evaluator.
package rfe_pkg;

    localparam int MaxTerms   = 4;
    localparam int CoefW      = 16;
    localparam int AccW       = 32;
    localparam int CfgIdxW    = 3;
    localparam int DefNumTerms = 4;
    localparam int DefDenTerms = 4;

    localparam logic signed [AccW-1:0] AccMax = 32'sh7fffffff;
    localparam logic signed [AccW-1:0] AccMin = 32'sh80000000;
    localparam logic signed [CoefW-1:0] DenOneReset = 16'sd4096;

    typedef logic signed [CoefW-1:0] coef_t;
    typedef logic signed [AccW-1:0]  acc_t;
    typedef coef_t coef_bank_t [MaxTerms];

    // Saturate a 64-bit value to 32 bits.
    function automatic acc_t clamp32(input logic signed [63:0] v, output logic hit);
        hit = 1'b0;
        clamp32 = v[AccW-1:0];
        if (v > 64'(signed'(AccMax)))
        begin
            hit = 1'b1;
            clamp32 = AccMax;
        end
        else if (v < 64'(signed'(AccMin)))
        begin
            hit = 1'b1;
            clamp32 = AccMin;
        end
    endfunction

endpackage

>>> design/rational_function_evaluator.sv
// Top level: coefficient registers, Horner step chain and quotient pipeline.
//
//  channel | ports                                   | handshake
//  input   | start, busy, sample_x                   | beat on start & !busy
//  result  | done, ratio_value, divide_by_zero, saturated | one-cycle strobe
//  config  | cfg_we, cfg_index, cfg_data             | write on cfg_we
//
// One sample a cycle. A result passes through the two-stage Horner steps,
// the divider input register, the 48 bit stages and the divider output
// register.
// Reset clears the valid bits and loads the coefficient reset values.
// busy is held low; the receiver cannot stall, so nothing ever waits.
module rational_function_evaluator
#(
    parameter int NUM_TERMS = rfe_pkg::DefNumTerms,
    parameter int DEN_TERMS = rfe_pkg::DefDenTerms
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [15:0]            sample_x,
    output logic                          done,
    output logic signed [31:0]            ratio_value,
    output logic                          divide_by_zero,
    output logic                          saturated,
    input  logic                          cfg_we,
    input  logic [rfe_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [rfe_pkg::CoefW-1:0]     cfg_data
);
    import rfe_pkg::*;

    localparam int NT = (NUM_TERMS < 1) ? 1 : ((NUM_TERMS > MaxTerms) ? MaxTerms : NUM_TERMS);
    localparam int DT = (DEN_TERMS < 1) ? 1 : ((DEN_TERMS > MaxTerms) ? MaxTerms : DEN_TERMS);
    localparam int ST = (NT > DT) ? NT : DT;

    coef_bank_t num_reg;
    coef_bank_t den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MaxTerms; k++)
            begin
                num_reg[k] <= '0;
                den_reg[k] <= (k == 0) ? DenOneReset : '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[CfgIdxW-1])
            begin
                den_reg[cfg_index[1:0]] <= cfg_data;
            end
            else
            begin
                num_reg[cfg_index[1:0]] <= cfg_data;
            end
        end
    end

    assign busy = 1'b0;

    logic               v   [ST+1];
    logic               s   [ST+1];
    logic signed [15:0] x   [ST+1];
    logic signed [31:0] pn  [ST+1];
    logic signed [31:0] pd  [ST+1];

    assign v[0]  = start;
    assign s[0]  = 1'b0;
    assign x[0]  = sample_x;
    assign pn[0] = '0;
    assign pd[0] = '0;

    // Step j handles coefficient ST-1-j; terms at or above a count are skipped.
    for (genvar j = 0; j < ST; j++)
    begin : g_step
        localparam int C = ST - 1 - j;
        rfe_horner_step u_step
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (v[j]),
            .in_sat   (s[j]),
            .in_x     (x[j]),
            .in_num   (pn[j]),
            .in_den   (pd[j]),
            .num_en   (C < NT),
            .den_en   (C < DT),
            .num_coef (num_reg[C]),
            .den_coef (den_reg[C]),
            .out_valid(v[j+1]),
            .out_sat  (s[j+1]),
            .out_x    (x[j+1]),
            .out_num  (pn[j+1]),
            .out_den  (pd[j+1])
        );
    end

    rfe_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v[ST]),
        .in_sat   (s[ST]),
        .in_num   (pn[ST]),
        .in_den   (pd[ST]),
        .out_valid(done),
        .out_ratio(ratio_value),
        .out_dz   (divide_by_zero),
        .out_sat  (saturated)
    );

endmodule

>>> design/rfe_horner_step.sv
// One registered Horner step: multiply, shift, saturate, add coefficient.
module rfe_horner_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_sat,
    input  logic signed [15:0]  in_x,
    input  logic signed [31:0]  in_num,
    input  logic signed [31:0]  in_den,
    input  logic                num_en,
    input  logic                den_en,
    input  logic signed [15:0]  num_coef,
    input  logic signed [15:0]  den_coef,
    output logic                out_valid,
    output logic                out_sat,
    output logic signed [15:0]  out_x,
    output logic signed [31:0]  out_num,
    output logic signed [31:0]  out_den
);
    import rfe_pkg::*;

    // Multiply stage
    logic               m_valid_reg;
    logic               m_sat_reg;
    logic signed [15:0] m_x_reg;
    logic signed [47:0] m_pn_reg;
    logic signed [47:0] m_pd_reg;
    logic signed [31:0] m_num_reg;
    logic signed [31:0] m_den_reg;

    logic signed [31:0] num_next;
    logic signed [31:0] den_next;
    logic               sat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            m_valid_reg <= in_valid;
            out_valid   <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m_sat_reg <= in_sat;
        m_x_reg   <= in_x;
        m_pn_reg  <= in_x * in_num;
        m_pd_reg  <= in_x * in_den;
        m_num_reg <= in_num;
        m_den_reg <= in_den;
        out_sat   <= sat_next;
        out_x     <= m_x_reg;
        out_num   <= num_next;
        out_den   <= den_next;
    end

    always_comb
    begin
        logic signed [63:0] pn;
        logic signed [63:0] pd;
        acc_t cn;
        acc_t cd;
        logic h0;
        logic h1;
        logic h2;
        logic h3;
        pn = 64'(m_pn_reg >>> 12);
        pd = 64'(m_pd_reg >>> 12);
        cn = clamp32(pn, h0);
        cn = clamp32(64'(cn) + 64'(num_coef) * 64'sd16, h1);
        cd = clamp32(pd, h2);
        cd = clamp32(64'(cd) + 64'(den_coef) * 64'sd16, h3);
        num_next = num_en ? cn : m_num_reg;
        den_next = den_en ? cd : m_den_reg;
        sat_next = m_sat_reg | (num_en & (h0 | h1)) | (den_en & (h2 | h3));
    end

endmodule

>>> design/rfe_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module rfe_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_sat,
    input  logic signed [31:0]  in_num,
    input  logic signed [31:0]  in_den,
    output logic                out_valid,
    output logic signed [31:0]  out_ratio,
    output logic                out_dz,
    output logic                out_sat
);
    import rfe_pkg::*;

    localparam int QW = 48;  // |P|*2^16 fits in 48 bits

    logic          v_reg   [QW+1];
    logic          s_reg   [QW+1];
    logic          neg_reg [QW+1];
    logic          dz_reg  [QW+1];
    logic          pp_reg  [QW+1];
    logic          pn_reg  [QW+1];
    logic [QW-1:0] n_reg   [QW+1];
    logic [31:0]   d_reg   [QW+1];
    logic [32:0]   r_reg   [QW+1];

    always_ff @(posedge clk)
    begin
        n_reg[0]   <= {in_num[31] ? 32'(-in_num) : 32'(in_num), 16'd0};
        d_reg[0]   <= in_den[31] ? 32'(-in_den) : 32'(in_den);
        r_reg[0]   <= '0;
        neg_reg[0] <= in_num[31] ^ in_den[31];
        dz_reg[0]  <= (in_den == '0);
        pp_reg[0]  <= ~in_num[31] & (in_num != '0);
        pn_reg[0]  <= in_num[31];
        s_reg[0]   <= in_sat;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_bit
        logic [32:0] trial;
        logic        fit;
        assign trial = {r_reg[i][31:0], n_reg[i][QW-1]};
        assign fit   = trial >= {1'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            r_reg[i+1]   <= fit ? trial - {1'b0, d_reg[i]} : trial;
            n_reg[i+1]   <= {n_reg[i][QW-2:0], fit};
            d_reg[i+1]   <= d_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            dz_reg[i+1]  <= dz_reg[i];
            pp_reg[i+1]  <= pp_reg[i];
            pn_reg[i+1]  <= pn_reg[i];
            s_reg[i+1]   <= s_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_valid <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < QW; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            out_valid <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [QW-1:0] q;
        logic          big;
        q = n_reg[QW];
        out_dz <= dz_reg[QW];
        if (dz_reg[QW])
        begin
            out_ratio <= pp_reg[QW] ? AccMax : (pn_reg[QW] ? AccMin : '0);
            out_sat   <= s_reg[QW] | pp_reg[QW] | pn_reg[QW];
        end
        else if (neg_reg[QW])
        begin
            big = q > 48'h80000000;
            out_ratio <= big ? AccMin : 32'(-q[31:0]);
            out_sat   <= s_reg[QW] | big;
        end
        else
        begin
            big = q > 48'h7fffffff;
            out_ratio <= big ? AccMax : q[31:0];
            out_sat   <= s_reg[QW] | big;
        end
    end

endmodule
